### rtl/rox_pkg.sv
// Package for the random opcode unit: field widths, generator state width,
// generator shift constants, the one-step xorshift function and the zero-seed fallback. No dependencies.
`timescale 1ns / 1ps

package rox_pkg;

  localparam int unsigned ArgW     = 16;
  localparam int unsigned ValueW   = 15;
  localparam int unsigned StateW   = 32;
  localparam int unsigned OutDataW = ValueW + 1 + StateW;
  localparam int unsigned CntW     = $clog2(StateW);

  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 5;

  localparam logic [StateW-1:0] ResetState = StateW'(1);

  typedef logic [StateW-1:0] xs_state_t;

  function automatic xs_state_t xs_advance(input xs_state_t x);
    xs_state_t a;
    xs_state_t b;
    a = x ^ (x << ShiftA);
    b = a ^ (a >> ShiftB);
    return b ^ (b << ShiftC);
  endfunction

  function automatic xs_state_t xs_seed(input xs_state_t s);
    return (s == '0) ? ResetState : s;
  endfunction

endpackage

### rtl/random_opcode_xorshift_unit.sv
// Top level of the random opcode unit: xorshift generator with a bit-serial
// restoring modulo and a registered output item. Depends on rox_pkg.
`timescale 1ns / 1ps

//  channel  | direction | handshake                      | payload
//  s_axis   | in        | s_axis_tvalid_i/s_axis_tready_o | argument [15:0]
//  m_axis   | out       | m_axis_tvalid_o/m_axis_tready_i | value, predictable, state
//  cfg      | in        | cfg_we_i                        | fallback_seed [31:0]
//
// A range item advances the generator on acceptance, runs the one-bit-per-cycle
// restoring remainder loop, then loads the output register. A reseed item sets
// the state on acceptance, then loads the output register. One item is in work
// at a time; the next is taken while a finished item waits in the output register.
// Reset: state 1, random mode, fallback seed 0, no output pending.
// A stalled output holds the last item in work until the output register frees.

module random_opcode_xorshift_unit
  import rox_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ArgW-1:0]     s_axis_tdata_i,  // [15:0] argument (signed)
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // [14:0] value, [15] predictable,
                                               // [47:16] generator_state
  input  logic                cfg_we_i,
  input  logic [StateW-1:0]   cfg_wdata_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StWait = 2'd2;

  logic [1:0]        st_q, st_d;
  logic [StateW-1:0] seed_q;
  xs_state_t         xs_q, xs_d;
  logic              pred_q, pred_d;
  logic [ValueW-1:0] div_q, div_d;
  logic [StateW-1:0] dvd_q, dvd_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0] val_q, val_d;
  logic              ovld_q, ovld_d;
  logic [OutDataW-1:0] odata_q, odata_d;

  logic              in_acc;
  logic              out_free;
  logic [ValueW:0]   trial;
  logic [ValueW:0]   diff;
  logic [ValueW-1:0] rem_step;
  logic [ArgW-1:0]   neg_arg;

  assign s_axis_tready_o = (st_q == StIdle);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !ovld_q || m_axis_tready_i;
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;

  assign trial    = {rem_q, dvd_q[StateW-1]};
  assign diff     = trial - {1'b0, div_q};
  assign rem_step = (trial >= {1'b0, div_q}) ? diff[ValueW-1:0] : trial[ValueW-1:0];
  assign neg_arg  = ArgW'(0) - s_axis_tdata_i;

  always_comb begin
    st_d    = st_q;
    xs_d    = xs_q;
    pred_d  = pred_q;
    div_d   = div_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    ovld_d  = ovld_q;
    odata_d = odata_q;
    if (m_axis_tready_i) begin
      ovld_d = 1'b0;
    end
    unique case (st_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tdata_i == '0) begin
            pred_d = 1'b0;
            xs_d   = xs_seed(seed_q);
            val_d  = '0;
            st_d   = StWait;
          end else if (s_axis_tdata_i[ArgW-1]) begin
            pred_d = 1'b1;
            // magnitude of a negative argument, 32768 included
            xs_d   = StateW'(neg_arg);
            val_d  = '0;
            st_d   = StWait;
          end else begin
            xs_d  = xs_advance(xs_q);
            dvd_d = xs_advance(xs_q);
            div_d = s_axis_tdata_i[ValueW-1:0];
            rem_d = '0;
            cnt_d = '0;
            st_d  = StDiv;
          end
        end
      end
      StDiv: begin
        rem_d = rem_step;
        dvd_d = {dvd_q[StateW-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(StateW - 1)) begin
          val_d = rem_step + ValueW'(1);
          st_d  = StWait;
        end
      end
      StWait: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          odata_d = {xs_q, pred_q, val_q};
          st_d    = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      seed_q <= '0;
      xs_q   <= ResetState;
      pred_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      xs_q   <= xs_d;
      pred_q <= pred_d;
      ovld_q <= ovld_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_q   <= div_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    val_q   <= val_d;
    odata_q <= odata_d;
  end

`ifndef SYNTHESIS
  a_state_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xs_q != '0) else $error("generator state reached zero");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StDiv |-> div_q != '0) else $error("modulo by zero range");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StDiv |-> rem_q < div_q) else $error("remainder not below range");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> st_q != StIdle) else $error("accepted item not in work");
`endif

endmodule
